// ===== design/spg_pkg.sv =====
// Package for the stepper pulse generator: command codes, widths and the
// divider request type. Depends on nothing; the divider and the top level import it.
`timescale 1ns / 1ps

package spg_pkg;

    // Command codes carried by an input request.
    localparam logic [2:0] CMD_TICK       = 3'd0;
    localparam logic [2:0] CMD_MOVE_BY    = 3'd1;
    localparam logic [2:0] CMD_MOVE_TO    = 3'd2;
    localparam logic [2:0] CMD_RUN        = 3'd3;
    localparam logic [2:0] CMD_STOP       = 3'd4;
    localparam logic [2:0] CMD_LIMIT_FALL = 3'd5;
    localparam logic [2:0] CMD_LIMIT_RISE = 3'd6;
    localparam logic [2:0] CMD_SET_ORIGIN = 3'd7;

    // Configuration register indexes.
    localparam logic [1:0] REG_STEPS_PER_UNIT = 2'd0;
    localparam logic [1:0] REG_ACCEL          = 2'd1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Divider operand widths: the dividend covers a move distance magnitude.
    localparam int DIV_W   = 34;
    localparam int DVS_W   = 16;
    localparam int DCNT_W  = 6;

    localparam int PERIOD_W = 20;
    localparam int RTIM_W   = 14;

    localparam logic [15:0] LIMIT_BACKOFF_SPEED = 16'd5;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [DVS_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_W-1:0]   quotient;
    } div_rsp_t;

endpackage

// ===== design/spg_in_if.sv =====
// Input channel of the stepper pulse generator: one command request.
// Depends on nothing.
`timescale 1ns / 1ps

interface spg_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [15:0] distance_units;
    logic signed [15:0] target_location;
    logic [15:0] speed_units;
    logic        direction_bit;

    modport source (output valid, command, distance_units, target_location,
                    speed_units, direction_bit, input ready);
    modport sink   (input valid, command, distance_units, target_location,
                    speed_units, direction_bit, output ready);
endinterface

// ===== design/spg_out_if.sv =====
// Result channel of the stepper pulse generator: outputs after one request.
// Depends on nothing.
`timescale 1ns / 1ps

interface spg_out_if;
    logic        valid;
    logic        ready;
    logic        pulse_level;
    logic        dir_level;
    logic        moving;
    logic signed [31:0] position_units;

    modport source (output valid, pulse_level, dir_level, moving,
                    position_units, input ready);
    modport sink   (input valid, pulse_level, dir_level, moving,
                    position_units, output ready);
endinterface

// ===== design/spg_cfg_if.sv =====
// Configuration write channel of the stepper pulse generator.
// Depends on nothing.
`timescale 1ns / 1ps

interface spg_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/spg_divider.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on spg_pkg for the operand widths and request types.
`timescale 1ns / 1ps

module spg_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  spg_pkg::div_req_t req,
    output spg_pkg::div_rsp_t rsp
);
    import spg_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DVS_W:0]    trial;
    logic              fits;

    // One shift-and-subtract step on the partial remainder.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(DIV_W - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = (req.divisor == '0) ? DVS_W'(1) : req.divisor;
        end
    end

    // Control state is reset; the operand shift registers need none.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== design/stepper_pulse_generator.sv =====
// Top level of the stepper step/direction pulse generator: command sequencer
// and motion state. Depends on spg_pkg, the channel interfaces and spg_divider.
`timescale 1ns / 1ps

// The block takes one request at a time on in_ch: a 1 us tick, or a motion
// command (move by, move to, run, stop, limit fall, limit rise, set origin).
// Each request gives exactly one result on out_ch with the pulse level, the
// direction level, the moving flag and the position in user units.
// Registers are written on cfg_ch, which is always ready; write them only
// while no request is in progress.
// A plain request makes one pass of the bit-serial divider, which scales the
// position for the result. A request that loads a new step period adds two
// divider passes, and a move to adds one more.
// in_ch.ready is high only while the sequencer is idle; a finished result
// waits in the output register, and the next request is taken meanwhile.
// If the receiver stalls, a second result waits until the first is taken.
// Reset clears all motion state, sets steps per unit to 1 and acceleration
// to 0; no result is pending after reset.

module stepper_pulse_generator
#(
    parameter int TICKS_PER_SECOND = 1000000,
    parameter int RAMP_INTERVAL    = 10000
)
(
    input  logic          clk,
    input  logic          rst_n,
    spg_in_if.sink        in_ch,
    spg_out_if.source     out_ch,
    spg_cfg_if.sink       cfg_ch
);
    import spg_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MT   = 3'd2;
    localparam logic [2:0] S_P1   = 3'd3;
    localparam logic [2:0] S_P2   = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam logic [DIV_W-1:0]    TPS_VAL = DIV_W'(TICKS_PER_SECOND);
    localparam logic [RTIM_W-1:0]   RI_VAL  = RTIM_W'(RAMP_INTERVAL);

    logic [2:0]  state_reg, state_next;
    logic        launched_reg, launched_next;

    // Latched request.
    logic [2:0]  cmd_reg;
    logic [15:0] dist_reg;
    logic [15:0] tloc_reg;
    logic [15:0] speed_reg;
    logic        dirin_reg;

    // Configuration.
    logic [7:0]  spu_reg, spu_next;
    logic [15:0] accel_reg, accel_next;

    // Motion state.
    logic [31:0]         pos_reg, pos_next;
    logic [31:0]         tog_reg, tog_next;
    logic                endless_reg, endless_next;
    logic                pulse_reg, pulse_next;
    logic                dir_reg, dir_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [PERIOD_W-1:0] stimer_reg, stimer_next;
    logic                ston_reg, ston_next;
    logic                rampon_reg, rampon_next;
    logic [RTIM_W-1:0]   rtimer_reg, rtimer_next;
    logic [15:0]         rspeed_reg, rspeed_next;
    logic [15:0]         rtarget_reg, rtarget_next;
    logic [15:0]         origin_reg, origin_next;

    // Work registers of the sequencer.
    logic [DIV_W-1:0]    mag_reg, mag_next;
    logic                mtdir_reg, mtdir_next;
    logic [15:0]         psp_reg, psp_next;
    logic [PERIOD_W-1:0] p1_reg, p1_next;

    // Output register.
    logic        ovalid_reg, ovalid_next;
    logic        opulse_reg, opulse_next;
    logic        odir_reg, odir_next;
    logic        omov_reg, omov_next;
    logic [31:0] opos_reg, opos_next;

    div_req_t    dreq;
    div_rsp_t    drsp;

    logic [7:0]          fac;
    logic [16:0]         sum17;
    logic signed [25:0]  goal26;
    logic [DIV_W-1:0]    diff;
    logic [DIV_W-1:0]    prod;
    logic [23:0]         dist_tog;
    logic [PERIOD_W-1:0] st_inc;
    logic [RTIM_W-1:0]   rt_inc;
    logic [16:0]         rsum;
    logic [31:0]         pos_abs;
    logic [31:0]         q32;

    assign fac = (spu_reg == 8'd0) ? 8'd1 : spu_reg;

    spg_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // Divider operands follow the sequencer state.
    always_comb
    begin
        pos_abs = pos_reg[31] ? (32'd0 - pos_reg) : pos_reg;
        dreq.start    = ((state_reg == S_MT) || (state_reg == S_P1) ||
                         (state_reg == S_P2) || (state_reg == S_OUT)) && !launched_reg;
        dreq.dividend = {2'b00, pos_abs};
        dreq.divisor  = {8'd0, fac};
        case (state_reg)
            S_MT:
            begin
                dreq.dividend = mag_reg;
            end
            S_P1:
            begin
                dreq.dividend = TPS_VAL;
            end
            S_P2:
            begin
                dreq.dividend = {{(DIV_W-PERIOD_W){1'b0}}, p1_reg};
                dreq.divisor  = psp_reg;
            end
            default:
            begin
                dreq.dividend = {2'b00, pos_abs};
            end
        endcase
    end

    // Sequencer and motion update.
    always_comb
    begin
        state_next    = state_reg;
        launched_next = launched_reg;
        spu_next      = spu_reg;
        accel_next    = accel_reg;
        pos_next      = pos_reg;
        tog_next      = tog_reg;
        endless_next  = endless_reg;
        pulse_next    = pulse_reg;
        dir_next      = dir_reg;
        period_next   = period_reg;
        stimer_next   = stimer_reg;
        ston_next     = ston_reg;
        rampon_next   = rampon_reg;
        rtimer_next   = rtimer_reg;
        rspeed_next   = rspeed_reg;
        rtarget_next  = rtarget_reg;
        origin_next   = origin_reg;
        mag_next      = mag_reg;
        mtdir_next    = mtdir_reg;
        psp_next      = psp_reg;
        p1_next       = p1_reg;
        ovalid_next   = ovalid_reg && !out_ch.ready;
        opulse_next   = opulse_reg;
        odir_next     = odir_reg;
        omov_next     = omov_reg;
        opos_next     = opos_reg;

        sum17    = {origin_reg[15], origin_reg} + {tloc_reg[15], tloc_reg};
        goal26   = $signed(sum17) * $signed({1'b0, fac});
        diff     = DIV_W'({{(DIV_W-26){goal26[25]}}, goal26})
                   - {{(DIV_W-32){pos_reg[31]}}, pos_reg};
        prod     = DIV_W'(drsp.quotient * fac);
        dist_tog = dist_reg * fac;
        st_inc   = stimer_reg + 1'b1;
        rt_inc   = rtimer_reg + 1'b1;
        rsum     = {1'b0, rspeed_reg} + {1'b0, accel_reg};
        q32      = drsp.quotient[31:0];

        if (dreq.start)
        begin
            launched_next = 1'b1;
        end
        if (drsp.done)
        begin
            launched_next = 1'b0;
        end

        // Register writes must arrive only while the block is idle; the block itself does not enforce it.
        if (cfg_ch.valid)
        begin
            if (cfg_ch.index == REG_STEPS_PER_UNIT)
            begin
                spu_next = cfg_ch.data[7:0];
            end
            else if (cfg_ch.index == REG_ACCEL)
            begin
                accel_next = cfg_ch.data;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_OUT;
                case (cmd_reg)
                    CMD_TICK:
                    begin
                        // The step timer is served before the ramp timer.
                        if (ston_reg)
                        begin
                            if (st_inc >= period_reg)
                            begin
                                stimer_next = '0;
                                if (tog_reg == 32'd0 && !endless_reg)
                                begin
                                    pulse_next   = 1'b0;
                                    ston_next    = 1'b0;
                                    rampon_next  = 1'b0;
                                    tog_next     = 32'd0;
                                    endless_next = 1'b0;
                                end
                                else
                                begin
                                    pulse_next = !pulse_reg;
                                    if (!endless_reg)
                                    begin
                                        tog_next = tog_reg - 1'b1;
                                    end
                                    pos_next = dir_reg ? (pos_reg - 1'b1) : (pos_reg + 1'b1);
                                end
                            end
                            else
                            begin
                                stimer_next = st_inc;
                            end
                        end
                        if (rampon_next)
                        begin
                            if (rt_inc >= RI_VAL)
                            begin
                                rtimer_next = '0;
                                if (rsum >= {1'b0, rtarget_reg})
                                begin
                                    rspeed_next = rtarget_reg;
                                    psp_next    = rtarget_reg;
                                    rampon_next = 1'b0;
                                end
                                else
                                begin
                                    rspeed_next = rsum[15:0];
                                    psp_next    = rsum[15:0];
                                end
                                stimer_next = '0;
                                ston_next   = 1'b1;
                                state_next  = S_P1;
                            end
                            else
                            begin
                                rtimer_next = rt_inc;
                            end
                        end
                    end
                    CMD_MOVE_BY:
                    begin
                        if (speed_reg != 16'd0)
                        begin
                            dir_next     = dirin_reg;
                            tog_next     = {8'd0, dist_tog};
                            endless_next = 1'b0;
                            if (accel_reg == 16'd0)
                            begin
                                psp_next    = speed_reg;
                                stimer_next = '0;
                                ston_next   = 1'b1;
                                state_next  = S_P1;
                            end
                            else
                            begin
                                rtarget_next = speed_reg;
                                rspeed_next  = 16'd0;
                                rtimer_next  = '0;
                                rampon_next  = 1'b1;
                            end
                        end
                    end
                    CMD_MOVE_TO:
                    begin
                        if (speed_reg != 16'd0 && diff != '0)
                        begin
                            mtdir_next = diff[DIV_W-1];
                            mag_next   = diff[DIV_W-1] ? (DIV_W'(0) - diff) : diff;
                            state_next = S_MT;
                        end
                    end
                    CMD_RUN:
                    begin
                        if (speed_reg != 16'd0)
                        begin
                            dir_next     = dirin_reg;
                            tog_next     = 32'd0;
                            endless_next = 1'b1;
                            psp_next     = speed_reg;
                            stimer_next  = '0;
                            ston_next    = 1'b1;
                            state_next   = S_P1;
                        end
                    end
                    CMD_STOP:
                    begin
                        ston_next    = 1'b0;
                        rampon_next  = 1'b0;
                        tog_next     = 32'd0;
                        endless_next = 1'b0;
                    end
                    CMD_LIMIT_FALL:
                    begin
                        // Back off forwards at the fixed slow speed.
                        rampon_next  = 1'b0;
                        dir_next     = 1'b0;
                        tog_next     = 32'd0;
                        endless_next = 1'b1;
                        psp_next     = LIMIT_BACKOFF_SPEED;
                        stimer_next  = '0;
                        ston_next    = 1'b1;
                        state_next   = S_P1;
                    end
                    CMD_LIMIT_RISE:
                    begin
                        ston_next    = 1'b0;
                        rampon_next  = 1'b0;
                        tog_next     = 32'd0;
                        endless_next = 1'b0;
                        pos_next     = 32'd0;
                    end
                    default:
                    begin
                        origin_next = tloc_reg;
                        pos_next    = {{16{tloc_reg[15]}}, tloc_reg};
                    end
                endcase
            end
            S_MT:
            begin
                // Whole units toward the goal, saturated to 32 bits of toggles.
                if (drsp.done)
                begin
                    dir_next     = mtdir_reg;
                    tog_next     = (prod[DIV_W-1:32] != '0) ? 32'hFFFF_FFFF : prod[31:0];
                    endless_next = 1'b0;
                    state_next   = S_OUT;
                    if (accel_reg == 16'd0)
                    begin
                        psp_next    = speed_reg;
                        stimer_next = '0;
                        ston_next   = 1'b1;
                        state_next  = S_P1;
                    end
                    else
                    begin
                        rtarget_next = speed_reg;
                        rspeed_next  = 16'd0;
                        rtimer_next  = '0;
                        rampon_next  = 1'b1;
                    end
                end
            end
            S_P1:
            begin
                if (drsp.done)
                begin
                    p1_next    = drsp.quotient[PERIOD_W-1:0];
                    state_next = S_P2;
                end
            end
            S_P2:
            begin
                if (drsp.done)
                begin
                    period_next = (drsp.quotient == '0) ? PERIOD_W'(1)
                                                        : drsp.quotient[PERIOD_W-1:0];
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (drsp.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Load the result once the output register is free.
                if (!ovalid_reg || out_ch.ready)
                begin
                    ovalid_next = 1'b1;
                    opulse_next = pulse_reg;
                    odir_next   = dir_reg;
                    omov_next   = (tog_reg != 32'd0) || endless_reg;
                    opos_next   = pos_reg[31] ? (32'd0 - q32) : q32;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and motion state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            launched_reg <= 1'b0;
            spu_reg      <= 8'd1;
            accel_reg    <= 16'd0;
            pos_reg      <= 32'd0;
            tog_reg      <= 32'd0;
            endless_reg  <= 1'b0;
            pulse_reg    <= 1'b0;
            dir_reg      <= 1'b0;
            period_reg   <= '0;
            stimer_reg   <= '0;
            ston_reg     <= 1'b0;
            rampon_reg   <= 1'b0;
            rtimer_reg   <= '0;
            rspeed_reg   <= 16'd0;
            rtarget_reg  <= 16'd0;
            origin_reg   <= 16'd0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
            spu_reg      <= spu_next;
            accel_reg    <= accel_next;
            pos_reg      <= pos_next;
            tog_reg      <= tog_next;
            endless_reg  <= endless_next;
            pulse_reg    <= pulse_next;
            dir_reg      <= dir_next;
            period_reg   <= period_next;
            stimer_reg   <= stimer_next;
            ston_reg     <= ston_next;
            rampon_reg   <= rampon_next;
            rtimer_reg   <= rtimer_next;
            rspeed_reg   <= rspeed_next;
            rtarget_reg  <= rtarget_next;
            origin_reg   <= origin_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    // Payload and work registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_ch.valid)
        begin
            cmd_reg   <= in_ch.command;
            dist_reg  <= in_ch.distance_units;
            tloc_reg  <= in_ch.target_location;
            speed_reg <= in_ch.speed_units;
            dirin_reg <= in_ch.direction_bit;
        end
        mag_reg    <= mag_next;
        mtdir_reg  <= mtdir_next;
        psp_reg    <= psp_next;
        p1_reg     <= p1_next;
        opulse_reg <= opulse_next;
        odir_reg   <= odir_next;
        omov_reg   <= omov_next;
        opos_reg   <= opos_next;
    end

    assign in_ch.ready           = (state_reg == S_IDLE);
    assign cfg_ch.ready          = 1'b1;
    assign out_ch.valid          = ovalid_reg;
    assign out_ch.pulse_level    = opulse_reg;
    assign out_ch.dir_level      = odir_reg;
    assign out_ch.moving         = omov_reg;
    assign out_ch.position_units = opos_reg;

endmodule

// ===== design/spg_checker.sv =====
// Port-level checker for the stepper pulse generator and its bind.
// Depends on the top level stepper_pulse_generator and its channel interfaces.
`timescale 1ns / 1ps

module spg_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_pulse,
    input logic        out_dir,
    input logic        out_moving,
    input logic [31:0] out_position
);

    // The sequencer is busy for the cycle after it takes a request.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while the previous one is still in work");

    // A new result only comes out of a busy sequencer.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a request in work");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(out_pulse) && $stable(out_dir) &&
                                       $stable(out_moving) && $stable(out_position)))
        else $error("result payload changed while stalled");

endmodule

bind stepper_pulse_generator spg_checker u_spg_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_pulse    (out_ch.pulse_level),
    .out_dir      (out_ch.dir_level),
    .out_moving   (out_ch.moving),
    .out_position (out_ch.position_units)
);
